// ===== design/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants of the compact block table.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

    localparam int CODE_BITS_DEF   = 16;
    localparam int BLOCK_SHIFT_DEF = 7;

    typedef enum logic [1:0] {
        K_WRITE_ONE   = 2'd0,
        K_WRITE_RANGE = 2'd1,
        K_COMPACT     = 2'd2,
        K_READ        = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        code;
        logic [15:0]        range_end;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] read_value;
        logic [16:0]        stored_count;
        logic               is_compact;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISP,
        ST_EX_IDX,
        ST_EX_RD,
        ST_EX_WR,
        ST_WR_RD,
        ST_WR_WR,
        ST_RD_IDX,
        ST_RD_ST,
        ST_RD_OUT,
        ST_CP_H,
        ST_CP_H2,
        ST_CP_J,
        ST_CP_JCHK,
        ST_CP_C1,
        ST_CP_C2,
        ST_CP_C3,
        ST_CP_MV_RD,
        ST_CP_MV_WR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/compact_block_table.sv =====
// ----------------------------------------------------------------------------
// compact_block_table
// Code-indexed value table with per-block hashing and block deduplication.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  in        in   i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       out  o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       in   i_cfg_we                  i_cfg_data (default value)
//
// One item at a time. A read does an index read and a store read; a write
// stores each code and updates its block hash, and on a compacted table
// first expands it, copying every code into the other bank (index read,
// store read, store write). Compaction reads each block's hash, checks it
// against stored block hashes, compares entries and moves unmatched blocks.
// After reset a clearing pass over all 2^CODE_BITS codes runs before the first
// beat is taken. The input stalls while an item is in progress. A finished
// result waits in the output register while the next item is accepted; an
// item that finishes while that register is still full waits until it drains.
//
`default_nettype none

module compact_block_table
    import cbt_pkg::*;
#(
    parameter int CODE_BITS   = CODE_BITS_DEF,
    parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CW = CODE_BITS;
    localparam int S  = BLOCK_SHIFT;
    localparam int NB = CODE_BITS - BLOCK_SHIFT;

    // Both banks share one memory; the top address bit is the bank.
    logic [15:0]   m_store [0:(2**(CW+1))-1];
    logic [CW-1:0] m_index [0:(2**NB)-1];
    logic [31:0]   m_hash  [0:(2**NB)-1];
    logic [31:0]   m_shash [0:(2**NB)-1];

    logic          st_we;
    logic [CW:0]   st_waddr, st_raddr;
    logic [15:0]   st_wdata, st_rdata;
    logic          ix_we;
    logic [NB-1:0] ix_waddr, ix_raddr;
    logic [CW-1:0] ix_wdata, ix_rdata;
    logic          hs_we;
    logic [NB-1:0] hs_waddr, hs_raddr;
    logic [31:0]   hs_wdata, hs_rdata;
    logic          sh_we;
    logic [NB-1:0] sh_waddr, sh_raddr;
    logic [31:0]   sh_wdata, sh_rdata;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_store[st_waddr] <= st_wdata;
        end
        st_rdata <= m_store[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ix_we) begin
            m_index[ix_waddr] <= ix_wdata;
        end
        ix_rdata <= m_index[ix_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hs_we) begin
            m_hash[hs_waddr] <= hs_wdata;
        end
        hs_rdata <= m_hash[hs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            m_shash[sh_waddr] <= sh_wdata;
        end
        sh_rdata <= m_shash[sh_raddr];
    end

    t_state        r_state, n_state;
    logic [15:0]   r_default, n_default;
    logic          r_bank, n_bank;
    logic          r_compact, n_compact;
    logic [CW:0]   r_count, n_count;
    logic [1:0]    r_kind, n_kind;
    logic [CW-1:0] r_code, n_code;
    logic [CW-1:0] r_last, n_last;
    logic [15:0]   r_value, n_value;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NB-1:0] r_blk, n_blk;
    logic [NB:0]   r_j, n_j;
    logic [NB:0]   r_used, n_used;
    logic [S-1:0]  r_k, n_k;
    logic [CW-1:0] r_ut, n_ut;
    logic          r_have, n_have;
    logic [31:0]   r_h, n_h;
    logic [15:0]   r_a, n_a;
    logic [15:0]   r_rd, n_rd;
    logic          r_ov, n_ov;
    t_out_item     r_out, n_out;

    logic [31:0]   sx2;
    logic [CW-1:0] blk_base;

    assign sx2      = {{15{r_value[15]}}, r_value, 1'b0};
    assign blk_base = {r_blk, {S{1'b0}}};

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_default <= '0;
            r_bank    <= 1'b0;
            r_compact <= 1'b0;
            r_count   <= (CW+1)'(2**CW);
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_default <= n_default;
            r_bank    <= n_bank;
            r_compact <= n_compact;
            r_count   <= n_count;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_code  <= n_code;
        r_last  <= n_last;
        r_value <= n_value;
        r_blk   <= n_blk;
        r_j     <= n_j;
        r_used  <= n_used;
        r_k     <= n_k;
        r_ut    <= n_ut;
        r_have  <= n_have;
        r_h     <= n_h;
        r_a     <= n_a;
        r_rd    <= n_rd;
        r_out   <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_default = i_cfg_we ? i_cfg_data : r_default;
        n_bank    = r_bank;
        n_compact = r_compact;
        n_count   = r_count;
        n_kind    = r_kind;
        n_code    = r_code;
        n_last    = r_last;
        n_value   = r_value;
        n_cnt     = r_cnt;
        n_blk     = r_blk;
        n_j       = r_j;
        n_used    = r_used;
        n_k       = r_k;
        n_ut      = r_ut;
        n_have    = r_have;
        n_h       = r_h;
        n_a       = r_a;
        n_rd      = r_rd;
        n_ov      = r_ov && i_out_stall;
        n_out     = r_out;

        st_we    = 1'b0;
        st_waddr = {r_bank, r_cnt};
        st_wdata = r_value;
        st_raddr = {r_bank, r_cnt};
        ix_we    = 1'b0;
        ix_waddr = r_blk;
        ix_wdata = blk_base;
        ix_raddr = r_cnt[CW-1:S];
        hs_we    = 1'b0;
        hs_waddr = r_cnt[CW-1:S];
        hs_wdata = (hs_rdata + sx2) | 32'd1;
        hs_raddr = r_cnt[CW-1:S];
        sh_we    = 1'b0;
        sh_waddr = r_used[NB-1:0];
        sh_wdata = r_h;
        sh_raddr = r_j[NB-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = {1'b0, r_cnt};
                st_wdata = '0;
                // The first blocks' worth of codes also seed index and hash.
                if (r_cnt[CW-1:NB] == '0) begin
                    ix_we    = 1'b1;
                    ix_waddr = r_cnt[NB-1:0];
                    ix_wdata = {r_cnt[NB-1:0], {S{1'b0}}};
                    hs_we    = 1'b1;
                    hs_waddr = r_cnt[NB-1:0];
                    hs_wdata = '0;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_in_data.kind;
                    n_code  = i_in_data.code[CW-1:0];
                    n_last  = (i_in_data.kind == K_WRITE_ONE) ?
                              i_in_data.code[CW-1:0] : i_in_data.range_end[CW-1:0];
                    n_value = i_in_data.value;
                    n_rd    = '0;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (t_kind'(r_kind))
                    K_WRITE_ONE, K_WRITE_RANGE: begin
                        if (r_compact) begin
                            n_cnt   = '0;
                            n_state = ST_EX_IDX;
                        end else if (r_code > r_last) begin
                            n_state = ST_DONE;
                        end else begin
                            n_cnt   = r_code;
                            n_state = ST_WR_RD;
                        end
                    end
                    K_COMPACT: begin
                        if (r_compact) begin
                            n_state = ST_DONE;
                        end else begin
                            n_blk   = '0;
                            n_used  = '0;
                            n_have  = 1'b0;
                            n_ut    = '0;
                            n_state = ST_CP_H;
                        end
                    end
                    K_READ: begin
                        n_state = ST_RD_IDX;
                    end
                endcase
            end
            ST_EX_IDX: begin
                ix_raddr = r_cnt[CW-1:S];
                n_state  = ST_EX_RD;
            end
            ST_EX_RD: begin
                st_raddr = {r_bank, ix_rdata + CW'(r_cnt[S-1:0])};
                n_state  = ST_EX_WR;
            end
            ST_EX_WR: begin
                st_we    = 1'b1;
                st_waddr = {~r_bank, r_cnt};
                st_wdata = st_rdata;
                // A block's index entry is no longer needed after its last code.
                if (r_cnt[S-1:0] == '1) begin
                    ix_we    = 1'b1;
                    ix_waddr = r_cnt[CW-1:S];
                    ix_wdata = {r_cnt[CW-1:S], {S{1'b0}}};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_bank    = ~r_bank;
                    n_compact = 1'b0;
                    n_count   = (CW+1)'(2**CW);
                    n_state   = ST_DISP;
                end else begin
                    n_state = ST_EX_IDX;
                end
            end
            ST_WR_RD: begin
                st_we    = 1'b1;
                st_waddr = {r_bank, r_cnt};
                st_wdata = r_value;
                hs_raddr = r_cnt[CW-1:S];
                n_state  = ST_WR_WR;
            end
            ST_WR_WR: begin
                if (r_value != r_default) begin
                    hs_we    = 1'b1;
                    hs_waddr = r_cnt[CW-1:S];
                    hs_wdata = (hs_rdata + sx2) | 32'd1;
                end
                if (r_cnt == r_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_WR_RD;
                end
            end
            ST_RD_IDX: begin
                ix_raddr = r_code[CW-1:S];
                n_state  = ST_RD_ST;
            end
            ST_RD_ST: begin
                st_raddr = {r_bank, ix_rdata + CW'(r_code[S-1:0])};
                n_state  = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                n_rd    = st_rdata;
                n_state = ST_DONE;
            end
            ST_CP_H: begin
                hs_raddr = r_blk;
                n_state  = ST_CP_H2;
            end
            ST_CP_H2: begin
                n_h = hs_rdata;
                if (hs_rdata == '0 && r_have) begin
                    ix_we    = 1'b1;
                    ix_waddr = r_blk;
                    ix_wdata = r_ut;
                    n_state  = ST_CP_H;
                end else begin
                    n_j     = '0;
                    n_state = ST_CP_J;
                end
            end
            ST_CP_J: begin
                n_k = '0;
                if (r_j == r_used) begin
                    n_state = ST_CP_MV_RD;
                end else begin
                    sh_raddr = r_j[NB-1:0];
                    n_state  = ST_CP_JCHK;
                end
            end
            ST_CP_JCHK: begin
                if (sh_rdata == r_h) begin
                    n_state = ST_CP_C1;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_CP_J;
                end
            end
            ST_CP_C1: begin
                st_raddr = {r_bank, r_blk, r_k};
                n_state  = ST_CP_C2;
            end
            ST_CP_C2: begin
                st_raddr = {r_bank, r_j[NB-1:0], r_k};
                n_a      = st_rdata;
                n_state  = ST_CP_C3;
            end
            ST_CP_C3: begin
                if (st_rdata != r_a) begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_CP_J;
                end else if (r_k == '1) begin
                    ix_we    = 1'b1;
                    ix_waddr = r_blk;
                    ix_wdata = {r_j[NB-1:0], {S{1'b0}}};
                    n_state  = ST_CP_H;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_CP_C1;
                end
            end
            ST_CP_MV_RD: begin
                st_raddr = {r_bank, r_blk, r_k};
                n_state  = ST_CP_MV_WR;
            end
            ST_CP_MV_WR: begin
                // The destination never lies above the source block.
                st_we    = 1'b1;
                st_waddr = {r_bank, r_used[NB-1:0], r_k};
                st_wdata = st_rdata;
                if (r_k == '1) begin
                    ix_we    = 1'b1;
                    ix_waddr = r_blk;
                    ix_wdata = {r_used[NB-1:0], {S{1'b0}}};
                    sh_we    = 1'b1;
                    sh_waddr = r_used[NB-1:0];
                    sh_wdata = r_h;
                    n_used   = r_used + 1'b1;
                    if (r_h == '0) begin
                        n_ut   = {r_used[NB-1:0], {S{1'b0}}};
                        n_have = 1'b1;
                    end
                    n_state = ST_CP_H;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_CP_MV_RD;
                end
            end
            ST_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov                 = 1'b1;
                    n_out.read_value     = r_rd;
                    n_out.stored_count   = 17'(r_count);
                    n_out.is_compact     = r_compact;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Block advance of the compaction sweep.
        if (n_state == ST_CP_H && r_state != ST_DISP) begin
            if (r_blk == '1) begin
                n_count   = {n_used, {S{1'b0}}};
                n_compact = 1'b1;
                n_state   = ST_DONE;
            end else begin
                n_blk = r_blk + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
